@@ sv/vmf_pkg.sv @@
// ----------------------------------------------------------------------------
// vmf_pkg
// Shared types, operation codes and the flag pipeline tick for the vector
// MAC flag pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vmf_pkg;

   // operation codes carried on req_func
   typedef logic [2:0] func_type;
   localparam func_type FUNC_CLASSIFY = 3'd0;
   localparam func_type FUNC_CLEAR    = 3'd1;
   localparam func_type FUNC_TICK     = 3'd2;
   localparam func_type FUNC_SWRESET  = 3'd3;
   localparam func_type FUNC_FLUSH    = 3'd4;

   localparam int unsigned LANES      = 4;
   localparam int unsigned FLAG_W     = 16;
   localparam int unsigned STATUS_W   = 12;

   localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
   localparam logic [31:0] MAG_MASK   = 32'h7fff_ffff;
   localparam logic [31:0] MAX_FINITE = 32'h7f7f_ffff;

   // per-lane bit groups, shifted by (3 - lane)
   localparam logic [15:0] SIGN_BIT   = 16'h0010;
   localparam logic [15:0] ZERO_BIT   = 16'h0001;
   localparam logic [15:0] UO_BITS    = 16'h1100;
   localparam logic [15:0] UZ_BITS    = 16'h0101;
   localparam logic [15:0] OVF_BIT    = 16'h1000;
   localparam logic [15:0] UOZ_BITS   = 16'h1101;
   localparam logic [15:0] LANE_BITS  = 16'h1111;

   typedef logic [LANES-1:0][FLAG_W-1:0] stages_type;

   typedef struct packed {
      stages_type                stages;
      logic [STATUS_W-1:0]       status;
   } pipe_type;

   // one step from the input register into the flag state
   typedef struct packed {
      logic                      advance;
      func_type                  func;
      logic [1:0]                lane;
      logic [FLAG_W-1:0]         class_pending;
   } step_type;

   // flag state as it stands after the step
   typedef struct packed {
      logic [FLAG_W-1:0]         mac_flags;
      logic [STATUS_W-1:0]       status;
   } view_type;

   // shift the pending word in; when stages 3 and 2 differed, fold the read stage into status
   function automatic pipe_type pipe_tick(pipe_type cur, logic [FLAG_W-1:0] pending,
                                          logic [1:0] sel);
      pipe_type          nxt;
      logic              armed;
      logic [FLAG_W-1:0] seen;
      armed         = (cur.stages[3] != cur.stages[2]);
      nxt.stages[3] = cur.stages[2];
      nxt.stages[2] = cur.stages[1];
      nxt.stages[1] = cur.stages[0];
      nxt.stages[0] = pending;
      nxt.status    = cur.status;
      seen          = nxt.stages[sel];
      if (armed) begin
         for (int g = 0; g < 4; g++) begin
            if (|seen[g*4 +: 4]) begin
               nxt.status[g] = 1'b1;
            end
         end
         nxt.status[11:6] = nxt.status[11:6] | nxt.status[5:0];
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

@@ sv/vmf_classify.sv @@
// ----------------------------------------------------------------------------
// vmf_classify
// Classifies one single-precision bit pattern for one lane: updates the
// pending flag word and produces the flushed or clamped pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module vmf_classify (
   input  wire logic [31:0] float_bits,
   input  wire logic [1:0]  lane,
   input  wire logic [15:0] pending,
   output logic      [15:0] pending_out,
   output logic      [31:0] result_bits
);

   logic [1:0] sh;
   logic [7:0] expo;

   assign sh   = ~lane;
   assign expo = float_bits[30:23];

   // set the lane's sign, zero, underflow and overflow bits
   always_comb begin
      pending_out = pending;
      result_bits = float_bits;
      if (float_bits[31]) begin
         pending_out = pending_out | (vmf_pkg::SIGN_BIT << sh);
      end else begin
         pending_out = pending_out & ~(vmf_pkg::SIGN_BIT << sh);
      end
      if ((float_bits & vmf_pkg::MAG_MASK) == 32'd0) begin
         pending_out = (pending_out | (vmf_pkg::ZERO_BIT << sh))
                       & ~(vmf_pkg::UO_BITS << sh);
      end else if (expo == 8'd0) begin
         // denormal: flush to signed zero
         pending_out = (pending_out | (vmf_pkg::UZ_BITS << sh))
                       & ~(vmf_pkg::OVF_BIT << sh);
         result_bits = float_bits & vmf_pkg::SIGN_MASK;
      end else if (expo == 8'hff) begin
         // infinity or NaN: clamp to signed largest finite
         pending_out = (pending_out | (vmf_pkg::OVF_BIT << sh))
                       & ~(vmf_pkg::UZ_BITS << sh);
         result_bits = (float_bits & vmf_pkg::SIGN_MASK) | vmf_pkg::MAX_FINITE;
      end else begin
         pending_out = pending_out & ~(vmf_pkg::UOZ_BITS << sh);
      end
   end

endmodule

`default_nettype wire

@@ sv/vmf_flag_pipe.sv @@
// ----------------------------------------------------------------------------
// vmf_flag_pipe
// Holds the pending flag word, the four flag stages, the sticky status word
// and the read stage select; applies one operation per advancing beat.
// ----------------------------------------------------------------------------
`default_nettype none

module vmf_flag_pipe (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire vmf_pkg::step_type step,
   input  wire logic              csr_valid,
   input  wire logic [1:0]        csr_flag_read_stage,
   output logic [15:0]            pending,
   output vmf_pkg::view_type      view
);

   logic [15:0]       pending_ff, pending_in;
   vmf_pkg::pipe_type pipe_ff, pipe_in;
   logic [1:0]        sel_ff;
   vmf_pkg::pipe_type t1, t2, t3, t4;

   assign pending = pending_ff;

   // chain of four ticks for flush; the first also serves a single tick
   assign t1 = vmf_pkg::pipe_tick(pipe_ff, pending_ff, sel_ff);
   assign t2 = vmf_pkg::pipe_tick(t1, pending_ff, sel_ff);
   assign t3 = vmf_pkg::pipe_tick(t2, pending_ff, sel_ff);
   assign t4 = vmf_pkg::pipe_tick(t3, pending_ff, sel_ff);

   // next state for the beat in the input register
   always_comb begin
      pending_in = pending_ff;
      pipe_in    = pipe_ff;
      case (step.func)
         vmf_pkg::FUNC_CLASSIFY: begin
            pending_in = step.class_pending;
         end
         vmf_pkg::FUNC_CLEAR: begin
            pending_in = pending_ff & ~(vmf_pkg::LANE_BITS << (~step.lane));
         end
         vmf_pkg::FUNC_TICK: begin
            pipe_in = t1;
         end
         vmf_pkg::FUNC_SWRESET: begin
            pipe_in = '0;
         end
         vmf_pkg::FUNC_FLUSH: begin
            pipe_in = t4;
         end
         default: begin
            pipe_in = pipe_ff;
         end
      endcase
   end

   assign view.mac_flags = pipe_in.stages[sel_ff];
   assign view.status    = pipe_in.status;

   // update state on advance, read stage on a configuration beat
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         pipe_ff    <= '0;
         sel_ff     <= 2'd3;
      end else begin
         if (step.advance) begin
            pending_ff <= pending_in;
            pipe_ff    <= pipe_in;
         end
         if (csr_valid) begin
            sel_ff <= csr_flag_read_stage;
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/vector_mac_flag_pipeline_top.sv @@
// ----------------------------------------------------------------------------
// vector_mac_flag_pipeline_top
// MAC status flag keeper for a four-lane float vector unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation beat (func, float_bits, lane); rsp_* returns
//   one beat per request: the clamped or echoed pattern, the flags of the
//   selected pipeline stage and the sticky status, all after the operation.
//   csr_* writes the flag read stage (2 bits, reset 3); write it only while
//   no request is in flight. csr_ready is always high.
// Path: an accepted request waits in the input register, then moves into
//   the result register, whose valid bit drives rsp_valid.
// Throughput: one beat per cycle while rsp_ready is high; flag state updates
//   as a beat moves from the input register into the result register, so the next beat sees it.
// Stall: while rsp_ready is low the response holds, one more beat waits in
//   the input register, and then req_ready drops.
// Reset: synchronous active-high reset clears the flag word, the stages,
//   the status, both valid bits, and sets the read stage to 3.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_mac_flag_pipeline_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_func,
   input  wire logic [31:0] req_float_bits,
   input  wire logic [1:0]  req_lane,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_result_bits,
   output logic [15:0]      rsp_mac_flags,
   output logic [11:0]      rsp_status_flags,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_flag_read_stage
);

   logic              in_valid_ff;
   vmf_pkg::func_type func_ff;
   logic [31:0]       bits_ff;
   logic [1:0]        lane_ff;
   logic              out_valid_ff;
   logic [31:0]       result_ff;
   logic [15:0]       mac_ff;
   logic [11:0]       status_ff;

   logic              advance;
   logic [15:0]       pending;
   logic [15:0]       class_pending;
   logic [31:0]       class_bits;
   vmf_pkg::step_type step;
   vmf_pkg::view_type view;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   vmf_classify u_classify (
      .float_bits  (bits_ff),
      .lane        (lane_ff),
      .pending     (pending),
      .pending_out (class_pending),
      .result_bits (class_bits)
   );

   assign step.advance       = advance;
   assign step.func          = func_ff;
   assign step.lane          = lane_ff;
   assign step.class_pending = class_pending;

   vmf_flag_pipe u_flag_pipe (
      .clock               (clock),
      .reset               (reset),
      .step                (step),
      .csr_valid           (csr_valid),
      .csr_flag_read_stage (csr_flag_read_stage),
      .pending             (pending),
      .view                (view)
   );

   // hold the request beat until it advances
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         func_ff <= req_func;
         bits_ff <= req_float_bits;
         lane_ff <= req_lane;
      end
   end

   // result register: load on advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= (func_ff == vmf_pkg::FUNC_CLASSIFY) ? class_bits : bits_ff;
         mac_ff    <= view.mac_flags;
         status_ff <= view.status;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_bits  = result_ff;
   assign rsp_mac_flags    = mac_ff;
   assign rsp_status_flags = status_ff;

endmodule

`default_nettype wire

@@ tb/vmf_flag_checker.sv @@
// ----------------------------------------------------------------------------
// vmf_flag_checker
// Watches the request, response and CSR channels of the vector MAC flag
// pipeline, keeps its own copy of the flag state, predicts one response
// beat per accepted request and compares responses in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmf_flag_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [2:0]  req_func,
   input  wire logic [31:0] req_float_bits,
   input  wire logic [1:0]  req_lane,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [31:0] rsp_result_bits,
   input  wire logic [15:0] rsp_mac_flags,
   input  wire logic [11:0] rsp_status_flags,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [1:0]  csr_flag_read_stage,
   output int unsigned      fail_count,
   output int unsigned      outstanding
);

   typedef struct packed {
      logic [31:0] result_bits;
      logic [15:0] mac_flags;
      logic [11:0] status_flags;
   } flag_beat_type;

   flag_beat_type rsp_due_q[$];

   // shadow flag state
   logic [1:0]  read_stage;
   logic [15:0] pending_word;
   logic [15:0] stage_flags [4];
   logic [11:0] sticky_status;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // shift the pending word in; when stages 3 and 2 differed, fold the read stage into status
   task automatic advance_stages();
      logic        armed;
      logic [15:0] seen;
      armed          = (stage_flags[3] != stage_flags[2]);
      stage_flags[3] = stage_flags[2];
      stage_flags[2] = stage_flags[1];
      stage_flags[1] = stage_flags[0];
      stage_flags[0] = pending_word;
      if (armed) begin
         seen = stage_flags[read_stage];
         for (int g = 0; g < 4; g++) begin
            if (|seen[g*4 +: 4]) begin
               sticky_status[g] = 1'b1;
            end
         end
         sticky_status[11:6] = sticky_status[11:6] | sticky_status[5:0];
      end
   endtask

   // set one lane's flags from a float pattern, return the clamped pattern
   task automatic classify_lane(input logic [31:0] bits, input logic [1:0] lane,
                                output logic [31:0] clamped);
      logic [1:0] sh;
      sh      = 2'd3 - lane;
      clamped = bits;
      if (bits[31]) begin
         pending_word = pending_word | (vmf_pkg::SIGN_BIT << sh);
      end else begin
         pending_word = pending_word & ~(vmf_pkg::SIGN_BIT << sh);
      end
      if ((bits & vmf_pkg::MAG_MASK) == 32'd0) begin
         pending_word = pending_word | (vmf_pkg::ZERO_BIT << sh);
         pending_word = pending_word & ~(vmf_pkg::UO_BITS << sh);
      end else if (bits[30:23] == 8'd0) begin
         // denormal flushes to signed zero
         pending_word = pending_word | (vmf_pkg::UZ_BITS << sh);
         pending_word = pending_word & ~(vmf_pkg::OVF_BIT << sh);
         clamped      = bits & vmf_pkg::SIGN_MASK;
      end else if (bits[30:23] == 8'hff) begin
         // infinity and NaN clamp to the signed largest finite value
         pending_word = pending_word | (vmf_pkg::OVF_BIT << sh);
         pending_word = pending_word & ~(vmf_pkg::UZ_BITS << sh);
         clamped      = (bits & vmf_pkg::SIGN_MASK) | vmf_pkg::MAX_FINITE;
      end else begin
         pending_word = pending_word & ~(vmf_pkg::UOZ_BITS << sh);
      end
   endtask

   // apply one request beat and form the response it should produce
   task automatic step_flag_state(input vmf_pkg::func_type func,
                                  input logic [31:0] bits,
                                  input logic [1:0] lane,
                                  output flag_beat_type beat);
      logic [31:0] res;
      res = bits;
      case (func)
         vmf_pkg::FUNC_CLASSIFY: begin
            classify_lane(bits, lane, res);
         end
         vmf_pkg::FUNC_CLEAR: begin
            pending_word = pending_word & ~(vmf_pkg::LANE_BITS << (2'd3 - lane));
         end
         vmf_pkg::FUNC_TICK: begin
            advance_stages();
         end
         vmf_pkg::FUNC_SWRESET: begin
            sticky_status = '0;
            for (int i = 0; i < 4; i++) begin
               stage_flags[i] = '0;
            end
         end
         vmf_pkg::FUNC_FLUSH: begin
            repeat (4) advance_stages();
         end
         default: begin
         end
      endcase
      beat.result_bits  = res;
      beat.mac_flags    = stage_flags[read_stage];
      beat.status_flags = sticky_status;
   endtask

   task automatic report_fail(input string what, input flag_beat_type want,
                              input flag_beat_type got);
      if (fail_count < 10) begin
         $display("[%0t] %s: want res=%h flags=%h status=%h, got res=%h flags=%h status=%h",
                  $realtime, what, want.result_bits, want.mac_flags, want.status_flags,
                  got.result_bits, got.mac_flags, got.status_flags);
      end
      fail_count = fail_count + 1;
   endtask

   // track beats on all three channels
   always @(posedge clock) begin
      flag_beat_type got;
      flag_beat_type want;
      if (reset) begin
         read_stage    = 2'd3;
         pending_word  = '0;
         sticky_status = '0;
         for (int i = 0; i < 4; i++) begin
            stage_flags[i] = '0;
         end
         rsp_due_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            read_stage = csr_flag_read_stage;
         end
         if (rsp_valid && rsp_ready) begin
            got.result_bits  = rsp_result_bits;
            got.mac_flags    = rsp_mac_flags;
            got.status_flags = rsp_status_flags;
            if (rsp_due_q.size() == 0) begin
               report_fail("response beat with nothing due", '0, got);
            end else begin
               want = rsp_due_q.pop_front();
               if (got.result_bits != want.result_bits) begin
                  report_fail("result_bits mismatch", want, got);
               end else if (got.mac_flags != want.mac_flags) begin
                  report_fail("mac_flags mismatch", want, got);
               end else if (got.status_flags != want.status_flags) begin
                  report_fail("status_flags mismatch", want, got);
               end
            end
         end
         if (req_valid && req_ready) begin
            step_flag_state(vmf_pkg::func_type'(req_func), req_float_bits, req_lane,
                            want);
            rsp_due_q.push_back(want);
         end
      end
      outstanding = rsp_due_q.size();
   end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the vector MAC flag pipeline: directed corner
// floats and every operation, then random operations under several read
// stage settings with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int unsigned CYCLE_LIMIT = 400000;

   // codes outside the defined operations
   localparam vmf_pkg::func_type FUNC_SPARE_5 = 3'd5;
   localparam vmf_pkg::func_type FUNC_SPARE_6 = 3'd6;
   localparam vmf_pkg::func_type FUNC_SPARE_7 = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_func;
   logic [31:0] req_float_bits;
   logic [1:0]  req_lane;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_result_bits;
   logic [15:0] rsp_mac_flags;
   logic [11:0] rsp_status_flags;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_flag_read_stage;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned cycle_count;
   logic        calm;

   vector_mac_flag_pipeline_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_float_bits     (req_float_bits),
      .req_lane           (req_lane),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_bits    (rsp_result_bits),
      .rsp_mac_flags      (rsp_mac_flags),
      .rsp_status_flags   (rsp_status_flags),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_flag_read_stage(csr_flag_read_stage)
   );

   vmf_flag_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_float_bits     (req_float_bits),
      .req_lane           (req_lane),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_bits    (rsp_result_bits),
      .rsp_mac_flags      (rsp_mac_flags),
      .rsp_status_flags   (rsp_status_flags),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_flag_read_stage(csr_flag_read_stage),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // stall the response side at random outside the calm stretch
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 17);
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("vector_mac_flag_pipeline_top: mismatch");
         $finish;
      end
   end

   // drive one request beat, idling first at random outside the calm stretch; returns after acceptance
   task automatic issue_op(input vmf_pkg::func_type func, input logic [31:0] bits,
                           input logic [1:0] lane);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_float_bits <= bits;
      req_lane       <= lane;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold off until every response has arrived, then let the pipe settle
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // write the flag read stage while idle
   task automatic write_read_stage(input logic [1:0] stage);
      wait_drained();
      csr_valid           <= 1'b1;
      csr_flag_read_stage <= stage;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // pick a float from one of the interesting classes
   function automatic logic [31:0] random_float();
      logic [31:0] bits;
      logic        sgn;
      logic [22:0] mant;
      logic [7:0]  expo;
      sgn  = 1'($urandom_range(0, 1));
      mant = 23'($urandom);
      expo = 8'($urandom_range(1, 254));
      case ($urandom_range(0, 9))
         0:       bits = {sgn, 31'd0};
         1, 2:    bits = {sgn, 8'd0, (mant == 23'd0) ? 23'd1 : mant};
         3, 4:    bits = {sgn, 8'hff, mant};
         5, 6, 7: bits = {sgn, expo, mant};
         default: bits = $urandom;
      endcase
      return bits;
   endfunction

   // random operation, mostly classify and tick so flags flow through
   task automatic issue_random_op();
      vmf_pkg::func_type func;
      int unsigned       pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         func = vmf_pkg::FUNC_CLASSIFY;
      end else if (pick < 66) begin
         func = vmf_pkg::FUNC_TICK;
      end else if (pick < 76) begin
         func = vmf_pkg::FUNC_CLEAR;
      end else if (pick < 87) begin
         func = vmf_pkg::FUNC_FLUSH;
      end else if (pick < 91) begin
         func = vmf_pkg::FUNC_SWRESET;
      end else begin
         func = 3'($urandom_range(5, 7));
      end
      issue_op(func, random_float(), 2'($urandom_range(0, 3)));
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_func            = vmf_pkg::FUNC_CLASSIFY;
      req_float_bits      = '0;
      req_lane            = '0;
      rsp_ready           = 1'b0;
      csr_valid           = 1'b0;
      csr_flag_read_stage = '0;
      cycle_count         = 0;
      calm                = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero, denormal, infinity, NaN and normal patterns across the lanes, and every operation
      issue_op(vmf_pkg::FUNC_CLASSIFY, 32'h0000_0000, 2'd0);
      issue_op(vmf_pkg::FUNC_CLASSIFY, 32'h8000_0000, 2'd1);
      issue_op(vmf_pkg::FUNC_CLASSIFY, 32'h0000_0001, 2'd2);
      issue_op(vmf_pkg::FUNC_CLASSIFY, 32'h807f_ffff, 2'd3);
      issue_op(vmf_pkg::FUNC_TICK,     32'h1234_5678, 2'd0);
      issue_op(vmf_pkg::FUNC_CLASSIFY, 32'h7f80_0000, 2'd0);
      issue_op(vmf_pkg::FUNC_CLASSIFY, 32'hffff_ffff, 2'd1);
      issue_op(vmf_pkg::FUNC_CLASSIFY, 32'h3f80_0000, 2'd2);
      issue_op(vmf_pkg::FUNC_CLASSIFY, 32'hff7f_ffff, 2'd3);
      issue_op(vmf_pkg::FUNC_TICK,     32'hffff_ffff, 2'd3);
      issue_op(vmf_pkg::FUNC_CLASSIFY, 32'h0080_0000, 2'd0);
      issue_op(vmf_pkg::FUNC_CLEAR,    32'h0000_0000, 2'd1);
      issue_op(vmf_pkg::FUNC_TICK,     32'h0000_0000, 2'd2);
      issue_op(vmf_pkg::FUNC_FLUSH,    32'hdead_beef, 2'd0);
      issue_op(vmf_pkg::FUNC_CLASSIFY, 32'h7fff_ffff, 2'd3);
      issue_op(vmf_pkg::FUNC_CLEAR,    32'hffff_ffff, 2'd3);
      issue_op(vmf_pkg::FUNC_TICK,     32'h0000_0000, 2'd0);
      issue_op(vmf_pkg::FUNC_SWRESET,  32'h5555_5555, 2'd2);
      issue_op(FUNC_SPARE_5,           32'haaaa_aaaa, 2'd1);
      issue_op(FUNC_SPARE_6,           32'h0000_0000, 2'd2);
      issue_op(FUNC_SPARE_7,           32'hffff_ffff, 2'd3);
      issue_op(vmf_pkg::FUNC_FLUSH,    32'h0000_0000, 2'd3);

      // random phases across read stage settings
      write_read_stage(2'd0);
      repeat (90) issue_random_op();
      write_read_stage(2'd2);
      repeat (45) issue_random_op();
      wait_drained();
      repeat (45) issue_random_op();
      write_read_stage(2'd1);
      calm = 1'b1;
      repeat (60) issue_random_op();
      calm = 1'b0;
      repeat (30) issue_random_op();
      write_read_stage(2'd3);
      repeat (90) issue_random_op();
      write_read_stage(2'd0);
      repeat (45) issue_random_op();
      write_read_stage(2'd3);
      repeat (45) issue_random_op();

      // drain and settle
      wait_drained();
      repeat (6) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("vector_mac_flag_pipeline_top: match");
      end else begin
         $display("vector_mac_flag_pipeline_top: mismatch");
      end
      $finish;
   end

endmodule
